// File: rtl/core/clw_pkg.sv
`default_nettype none

package clw_pkg;

  // Display geometry and controller command bytes.
  localparam logic [7:0] LINE_LEN  = 8'd16;
  localparam logic [7:0] WRAP_CMD  = 8'hC0;
  localparam logic [7:0] CLEAR_CMD = 8'h01;
  localparam logic [7:0] HOME_CMD  = 8'h80;
  localparam logic [7:0] ADDR_CMD  = 8'h80;
  localparam logic [7:0] LINE2_BIT = 8'h40;
  localparam logic [7:0] CYR_FIRST = 8'hC0;

  // Bar graph glyph for a completely filled cell.
  localparam logic [7:0] FULL_CELL = 8'd5;
  // floor(q * 205 / 1024) equals floor(q / 5) for every 10-bit q.
  localparam logic [7:0] RECIP_5   = 8'd205;

  // Operation codes carried in the kind field.
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_GOTO  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_BAR   = 2'd3;

  // Cyrillic letters of the code page (0xC0 to 0xFF) mapped to the controller's font.
  localparam logic [7:0] CYR_MAP [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] column;
    logic [1:0] row;
    logic [6:0] bar_percent;
    logic [4:0] bar_cells;
  } op_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] write_byte;
    logic       last;
  } wr_t;

  // Microcode fields.
  typedef enum logic [1:0] {EMIT_NONE, EMIT_ALWAYS, EMIT_IF_WRAP} emit_t;
  typedef enum logic [2:0] {SRC_WRAP, SRC_CHAR, SRC_GOTO, SRC_CLEAR, SRC_HOME,
                            SRC_CELL} src_t;
  typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_BAR} last_t;
  typedef enum logic [1:0] {CUR_HOLD, CUR_INC, CUR_GOTO, CUR_ZERO} cur_t;
  typedef enum logic [2:0] {DP_NONE, DP_LOAD, DP_MUL, DP_DIV, DP_CELL} dp_t;
  typedef enum logic [2:0] {SEQ_NEXT, SEQ_JUMP, SEQ_DISPATCH, SEQ_IF_EMPTY,
                            SEQ_BAR} seq_t;

  typedef logic [3:0] step_t;

  // Program addresses.
  localparam step_t STEP_FETCH   = 4'd0;
  localparam step_t STEP_PC_WRAP = 4'd1;
  localparam step_t STEP_PC_DATA = 4'd2;
  localparam step_t STEP_GOTO    = 4'd3;
  localparam step_t STEP_CLEAR   = 4'd4;
  localparam step_t STEP_HOME    = 4'd5;
  localparam step_t STEP_BMUL    = 4'd6;
  localparam step_t STEP_BDIV    = 4'd7;
  localparam step_t STEP_BWRAP   = 4'd8;
  localparam step_t STEP_BCELL   = 4'd9;

  typedef struct packed {
    emit_t emit;
    src_t  src;
    logic  is_data;
    last_t last;
    cur_t  cur;
    dp_t   dp;
    seq_t  seq;
    step_t target;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    ucode_t uc;
    logic   fire;
  } ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic wrap;
    logic empty;
    logic bar_last;
    logic out_free;
  } sts_t;

  // Control store: one word per program step.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    unique case (s)
      STEP_FETCH:   w = '{EMIT_NONE, SRC_WRAP, 1'b0, LAST_NO, CUR_HOLD, DP_LOAD,
                          SEQ_DISPATCH, STEP_FETCH};
      STEP_PC_WRAP: w = '{EMIT_IF_WRAP, SRC_WRAP, 1'b0, LAST_NO, CUR_HOLD, DP_NONE,
                          SEQ_NEXT, STEP_FETCH};
      STEP_PC_DATA: w = '{EMIT_ALWAYS, SRC_CHAR, 1'b1, LAST_YES, CUR_INC, DP_NONE,
                          SEQ_JUMP, STEP_FETCH};
      STEP_GOTO:    w = '{EMIT_ALWAYS, SRC_GOTO, 1'b0, LAST_YES, CUR_GOTO, DP_NONE,
                          SEQ_JUMP, STEP_FETCH};
      STEP_CLEAR:   w = '{EMIT_ALWAYS, SRC_CLEAR, 1'b0, LAST_NO, CUR_HOLD, DP_NONE,
                          SEQ_NEXT, STEP_FETCH};
      STEP_HOME:    w = '{EMIT_ALWAYS, SRC_HOME, 1'b0, LAST_YES, CUR_ZERO, DP_NONE,
                          SEQ_JUMP, STEP_FETCH};
      STEP_BMUL:    w = '{EMIT_NONE, SRC_WRAP, 1'b0, LAST_NO, CUR_HOLD, DP_MUL,
                          SEQ_IF_EMPTY, STEP_FETCH};
      STEP_BDIV:    w = '{EMIT_NONE, SRC_WRAP, 1'b0, LAST_NO, CUR_HOLD, DP_DIV,
                          SEQ_NEXT, STEP_FETCH};
      STEP_BWRAP:   w = '{EMIT_IF_WRAP, SRC_WRAP, 1'b0, LAST_NO, CUR_HOLD, DP_NONE,
                          SEQ_NEXT, STEP_FETCH};
      STEP_BCELL:   w = '{EMIT_ALWAYS, SRC_CELL, 1'b1, LAST_BAR, CUR_INC, DP_CELL,
                          SEQ_BAR, STEP_BWRAP};
      default:      w = '{EMIT_NONE, SRC_WRAP, 1'b0, LAST_NO, CUR_HOLD, DP_NONE,
                          SEQ_JUMP, STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/clw_seq.sv
`default_nettype none

module clw_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  input  wire logic [1:0]    kind,
  input  wire clw_pkg::sts_t sts,
  output clw_pkg::ctl_t      ctl,
  output logic               op_stall
);

  clw_pkg::step_t  step;
  clw_pkg::step_t  step_next;
  clw_pkg::step_t  branch;
  clw_pkg::step_t  dispatch;
  clw_pkg::ucode_t uc;
  logic            need_out;
  logic            go;

  // Fetch the control word of the current step.
  assign uc = clw_pkg::ucode_rom(step);

  // A step that writes waits for room in the output register; the fetch step
  // waits for an operation.
  assign need_out = (uc.emit == clw_pkg::EMIT_ALWAYS) ||
                    ((uc.emit == clw_pkg::EMIT_IF_WRAP) && sts.wrap);
  assign go = (uc.seq == clw_pkg::SEQ_DISPATCH) ? op_valid
                                                 : (!need_out || sts.out_free);

  assign ctl.uc   = uc;
  assign ctl.fire = go;
  assign op_stall = (step != clw_pkg::STEP_FETCH);

  // Entry point of each operation's routine.
  always_comb begin
    unique case (kind)
      clw_pkg::KIND_PUT:   dispatch = clw_pkg::STEP_PC_WRAP;
      clw_pkg::KIND_GOTO:  dispatch = clw_pkg::STEP_GOTO;
      clw_pkg::KIND_CLEAR: dispatch = clw_pkg::STEP_CLEAR;
      clw_pkg::KIND_BAR:   dispatch = clw_pkg::STEP_BMUL;
      default:             dispatch = clw_pkg::STEP_FETCH;
    endcase
  end

  // Sequencing: fall through, jump, dispatch or conditional branch.
  always_comb begin
    unique case (uc.seq)
      clw_pkg::SEQ_NEXT:     branch = step + 4'd1;
      clw_pkg::SEQ_JUMP:     branch = uc.target;
      clw_pkg::SEQ_DISPATCH: branch = dispatch;
      clw_pkg::SEQ_IF_EMPTY: branch = sts.empty ? uc.target : step + 4'd1;
      clw_pkg::SEQ_BAR:      branch = sts.bar_last ? clw_pkg::STEP_FETCH : uc.target;
      default:               branch = clw_pkg::STEP_FETCH;
    endcase
    step_next = go ? branch : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= clw_pkg::STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/clw_dp.sv
`default_nettype none

module clw_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire clw_pkg::op_t  op,
  input  wire clw_pkg::ctl_t ctl,
  output clw_pkg::sts_t      sts,
  output logic               wr_valid,
  output clw_pkg::wr_t       wr,
  input  wire logic          wr_stall
);

  clw_pkg::op_t fld;
  logic [7:0]   cursor;
  logic [11:0]  prod;
  logic [7:0]   cell_v;
  logic [4:0]   cells_left;

  logic [7:0]   row_m1;
  logic [7:0]   col_m1;
  logic [7:0]   goto_byte;
  logic [7:0]   goto_pos;
  logic [7:0]   char_byte;
  logic [7:0]   cell_byte;
  logic [9:0]   quarter;
  logic [17:0]  quo_full;
  logic [7:0]   out_byte;
  logic         out_last;
  logic         emit_now;
  logic         out_free;
  logic         bar_last;

  // Status toward the sequencer.
  assign out_free = !wr_valid || !wr_stall;
  assign bar_last = (cell_v <= clw_pkg::FULL_CELL) || (cells_left == 5'd1);
  assign sts.wrap     = (cursor == clw_pkg::LINE_LEN);
  assign sts.empty    = (fld.bar_cells == 5'd0);
  assign sts.bar_last = bar_last;
  assign sts.out_free = out_free;

  assign emit_now = ctl.fire &&
                    ((ctl.uc.emit == clw_pkg::EMIT_ALWAYS) ||
                     ((ctl.uc.emit == clw_pkg::EMIT_IF_WRAP) && sts.wrap));

  // Set-address command and new position for go to, all modulo 256.
  assign row_m1    = {6'd0, fld.row} - 8'd1;
  assign col_m1    = {3'd0, fld.column} - 8'd1;
  assign goto_byte = clw_pkg::ADDR_CMD | col_m1 |
                     ((row_m1 != 8'd0) ? clw_pkg::LINE2_BIT : 8'd0);
  assign goto_pos  = 8'(row_m1 * clw_pkg::LINE_LEN) + col_m1;

  // Character decode through the Cyrillic table.
  assign char_byte = (fld.char_code >= clw_pkg::CYR_FIRST) ?
                     clw_pkg::CYR_MAP[fld.char_code[5:0]] : fld.char_code;

  // Bar graph glyph for the current cell.
  assign cell_byte = (cell_v > clw_pkg::FULL_CELL) ? clw_pkg::FULL_CELL : cell_v;

  // Divide the registered product by 20: drop two bits, then scale by 1/5.
  assign quarter  = prod[11:2];
  assign quo_full = 18'(quarter) * 18'(clw_pkg::RECIP_5);

  // Byte source selection.
  always_comb begin
    unique case (ctl.uc.src)
      clw_pkg::SRC_WRAP:  out_byte = clw_pkg::WRAP_CMD;
      clw_pkg::SRC_CHAR:  out_byte = char_byte;
      clw_pkg::SRC_GOTO:  out_byte = goto_byte;
      clw_pkg::SRC_CLEAR: out_byte = clw_pkg::CLEAR_CMD;
      clw_pkg::SRC_HOME:  out_byte = clw_pkg::HOME_CMD;
      clw_pkg::SRC_CELL:  out_byte = cell_byte;
      default:            out_byte = clw_pkg::WRAP_CMD;
    endcase
  end

  // Final-write marker.
  always_comb begin
    unique case (ctl.uc.last)
      clw_pkg::LAST_NO:  out_last = 1'b0;
      clw_pkg::LAST_YES: out_last = 1'b1;
      clw_pkg::LAST_BAR: out_last = bar_last;
      default:           out_last = 1'b0;
    endcase
  end

  // Cursor and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= 8'd0;
      wr_valid <= 1'b0;
    end else begin
      if (ctl.fire) begin
        unique case (ctl.uc.cur)
          clw_pkg::CUR_HOLD: cursor <= cursor;
          clw_pkg::CUR_INC:  cursor <= cursor + 8'd1;
          clw_pkg::CUR_GOTO: cursor <= goto_pos;
          clw_pkg::CUR_ZERO: cursor <= 8'd0;
          default:           cursor <= cursor;
        endcase
      end
      if (emit_now) begin
        wr_valid <= 1'b1;
      end else if (!wr_stall) begin
        wr_valid <= 1'b0;
      end
    end
  end

  // Operation fields, bar graph working registers and the output payload.
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      unique case (ctl.uc.dp)
        clw_pkg::DP_NONE: ;
        clw_pkg::DP_LOAD: fld <= op;
        clw_pkg::DP_MUL: begin
          prod       <= 12'(fld.bar_percent) * 12'(fld.bar_cells);
          cells_left <= fld.bar_cells;
        end
        clw_pkg::DP_DIV:  cell_v <= quo_full[17:10];
        clw_pkg::DP_CELL: begin
          cell_v     <= cell_v - clw_pkg::FULL_CELL;
          cells_left <= cells_left - 5'd1;
        end
        default: ;
      endcase
    end
    if (emit_now) begin
      wr.is_data    <= ctl.uc.is_data;
      wr.write_byte <= out_byte;
      wr.last       <= out_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/char_lcd_text_writer.sv
// Flow: an operation runs one routine, and op_stall holds off the next until it is back
// at fetch. Put character writes the second-line command on a wrap, then the character;
// go to writes a set-address command; clear writes clear, then home; a bar graph writes
// each cell after any wrap; a write step waits while the output is stalled.
// Reset: synchronous and active high; clears the cursor position to zero, empties the
// output register and returns the sequencer to its fetch step.
`default_nettype none

module char_lcd_text_writer (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         op_valid,
  output logic              op_stall,
  input  wire clw_pkg::op_t op,
  output logic              wr_valid,
  input  wire logic         wr_stall,
  output clw_pkg::wr_t      wr
);

  clw_pkg::ctl_t ctl;
  clw_pkg::sts_t sts;

  // Microprogram sequencer.
  clw_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .kind     (op.kind),
    .sts      (sts),
    .ctl      (ctl),
    .op_stall (op_stall)
  );

  // Datapath with cursor, bar graph arithmetic and output register.
  clw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .ctl      (ctl),
    .sts      (sts),
    .wr_valid (wr_valid),
    .wr       (wr),
    .wr_stall (wr_stall)
  );

  // An operation transfer always starts a routine, so the next cycle is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_stall) |=> op_stall)
    else $error("sequencer did not leave fetch after an operation transfer");

  // Back at fetch, any write still held must be the last of its operation.
  a_idle_holds_last: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && !op_stall) |-> wr.last)
    else $error("sequencer returned to fetch before the final write");

  // Command writes are set-address, clear or second-line commands only.
  a_cmd_byte: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && !wr.is_data) |-> (wr.write_byte[7] || (wr.write_byte == 8'h01)))
    else $error("unexpected command byte");

endmodule

`default_nettype wire
